FILE: sv/cfdt_pkg.sv
// ----------------------------------------------------------------------------
// cfdt_pkg
// Shared widths, types and face codes for the cube face direction-to-texel
// pipeline.
// ----------------------------------------------------------------------------
package cfdt_pkg;

  localparam int DIR_WIDTH   = 18;
  localparam int SIDE_WIDTH  = 13;
  localparam int FACE_WIDTH  = 3;
  localparam int HIT_WIDTH   = 13;
  localparam int U_WIDTH     = 16;
  localparam int V_WIDTH     = 15;

  // |dir| reaches 2^(DIR_WIDTH-1), so the magnitude needs DIR_WIDTH bits
  localparam int MAG_WIDTH   = DIR_WIDTH;
  localparam int PROD_WIDTH  = MAG_WIDTH + SIDE_WIDTH;
  // dividend = mag*L + mx
  localparam int NUM_WIDTH   = PROD_WIDTH + 1;
  // divisor = 2*mx
  localparam int DEN_WIDTH   = MAG_WIDTH + 1;
  // rounded quotient never exceeds (L+1)/2
  localparam int QUOT_WIDTH  = SIDE_WIDTH;
  // k*L/2 offsets for k up to 7
  localparam int HALF_WIDTH  = SIDE_WIDTH + 2;
  localparam int CALC_WIDTH  = SIDE_WIDTH + 4;

  localparam logic [SIDE_WIDTH-1:0] SIDE_RESET = SIDE_WIDTH'(1024);

  localparam logic [FACE_WIDTH-1:0] FACE_FRONT  = 3'd0;
  localparam logic [FACE_WIDTH-1:0] FACE_BACK   = 3'd1;
  localparam logic [FACE_WIDTH-1:0] FACE_LEFT   = 3'd2;
  localparam logic [FACE_WIDTH-1:0] FACE_RIGHT  = 3'd3;
  localparam logic [FACE_WIDTH-1:0] FACE_TOP    = 3'd4;
  localparam logic [FACE_WIDTH-1:0] FACE_BOTTOM = 3'd5;

  typedef logic [MAG_WIDTH-1:0]          mag_t;
  typedef logic [NUM_WIDTH-1:0]          num_t;
  typedef logic [DEN_WIDTH-1:0]          den_t;
  typedef logic [QUOT_WIDTH-1:0]         quot_t;
  typedef logic [2:0][NUM_WIDTH-1:0]     num_vec_t;
  typedef logic [2:0][QUOT_WIDTH-1:0]    quot_vec_t;

  // per-request sideband that rides along the divider
  typedef struct packed {
    logic [2:0]            neg;
    logic [FACE_WIDTH-1:0] face;
    logic                  zero;
  } tag_t;

endpackage

FILE: sv/cube_face_direction_to_texel.sv
// ----------------------------------------------------------------------------
// cube_face_direction_to_texel
// Direction vector to cube face, hit point and cross-layout texel.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per direction (x, y, z signed) on a tvalid/tready pair.
//   out_* : one result per request, in order: face, rounded hit point, texel
//           u/v in the 4L x 3L cross image; out_tuser flags a zero vector,
//           in which case every data field reads zero.
//   cfg_* : write of the cube edge length L; write only while no request is
//           in flight.
// Pipeline: 18 register stages (4 front stages, one divider stage per quotient
//   bit = SIDE_WIDTH stages, 1 output stage).
// Throughput: one request per cycle unless out_tready stalls; the divider is
//   fully pipelined, one quotient bit per stage, so the chain of SIDE_WIDTH
//   stages sets the depth.
// Reset: rst_n low clears all valid bits and loads L = 1024.
// Stall: each stage holds while its successor is full and stalled; empty
//   stages keep filling, so in_tready only drops once the pipe is packed.
// ----------------------------------------------------------------------------
module cube_face_direction_to_texel (
  input  logic                            clk,
  input  logic                            rst_n,
  // config
  input  logic                            cfg_wen,
  input  logic [cfdt_pkg::SIDE_WIDTH-1:0] cfg_wdata,
  // request: [17:0] dir_x, [35:18] dir_y, [53:36] dir_z, [55:54] zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [55:0]                     in_tdata,
  // result: [2:0] face, [15:3] hit_x, [28:16] hit_y, [41:29] hit_z,
  //         [57:42] texel_u, [72:58] texel_v, [79:73] zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [79:0]                     out_tdata,
  // [0] zero_vector
  output logic [0:0]                      out_tuser
);
  import cfdt_pkg::*;

  // --------------------------------------------------------------------------
  // Edge length, face offsets: user must hold static while requests in flight
  // --------------------------------------------------------------------------
  logic [SIDE_WIDTH-1:0] side_r;
  logic [HALF_WIDTH-1:0] half1_r, half3_r, half5_r, half7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
    end else if (cfg_wen) begin
      side_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    logic [SIDE_WIDTH+2:0] l1;
    l1 = (SIDE_WIDTH+3)'(side_r);
    half1_r <= HALF_WIDTH'(l1 >> 1);
    half3_r <= HALF_WIDTH'((l1 + (l1 << 1)) >> 1);
    half5_r <= HALF_WIDTH'((l1 + (l1 << 2)) >> 1);
    half7_r <= HALF_WIDTH'(((l1 << 3) - l1) >> 1);
  end

  // --------------------------------------------------------------------------
  // Stage ready chain
  // --------------------------------------------------------------------------
  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r, out_vld_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic div_in_ready, div_out_valid;

  assign rdy_e     = !out_vld_r || out_tready;
  assign rdy_d     = !vld_d_r || div_in_ready;
  assign rdy_c     = !vld_c_r || rdy_d;
  assign rdy_b     = !vld_b_r || rdy_c;
  assign rdy_a     = !vld_a_r || rdy_b;
  assign in_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      if (rdy_a) vld_a_r <= in_tvalid;
      if (rdy_b) vld_b_r <= vld_a_r;
      if (rdy_c) vld_c_r <= vld_b_r;
      if (rdy_d) vld_d_r <= vld_c_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: magnitudes and signs
  // --------------------------------------------------------------------------
  mag_t       mag_a_r [3];
  logic [2:0] neg_a_r;

  always_ff @(posedge clk) begin
    logic [DIR_WIDTH-1:0] c;
    if (rdy_a && in_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        c = in_tdata[i*DIR_WIDTH +: DIR_WIDTH];
        neg_a_r[i] <= c[DIR_WIDTH-1];
        mag_a_r[i] <= c[DIR_WIDTH-1] ? (~c + 1'b1) : c;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: major axis (ties favor x, then y), face, zero check
  // --------------------------------------------------------------------------
  mag_t mag_b_r [3];
  mag_t mx_b_r;
  tag_t tag_b_r;
  mag_t mx_nxt;
  logic [FACE_WIDTH-1:0] face_nxt;

  always_comb begin
    mx_nxt   = mag_a_r[0];
    face_nxt = neg_a_r[0] ? FACE_BACK : FACE_FRONT;
    if (mag_a_r[1] > mx_nxt) begin
      mx_nxt   = mag_a_r[1];
      face_nxt = neg_a_r[1] ? FACE_RIGHT : FACE_LEFT;
    end
    if (mag_a_r[2] > mx_nxt) begin
      mx_nxt   = mag_a_r[2];
      face_nxt = neg_a_r[2] ? FACE_BOTTOM : FACE_TOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && vld_a_r) begin
      mag_b_r      <= mag_a_r;
      mx_b_r       <= mx_nxt;
      tag_b_r.neg  <= neg_a_r;
      tag_b_r.face <= face_nxt;
      tag_b_r.zero <= (mx_nxt == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: mag * L
  // --------------------------------------------------------------------------
  logic [PROD_WIDTH-1:0] prod_c_r [3];
  mag_t                  mx_c_r;
  tag_t                  tag_c_r;

  always_ff @(posedge clk) begin
    if (rdy_c && vld_b_r) begin
      for (int i = 0; i < 3; i++) begin
        prod_c_r[i] <= PROD_WIDTH'(mag_b_r[i]) * PROD_WIDTH'(side_r);
      end
      mx_c_r  <= mx_b_r;
      tag_c_r <= tag_b_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: round(mag*L / (2*mx)) = floor((mag*L + mx) / (2*mx))
  // --------------------------------------------------------------------------
  num_vec_t num_d_r;
  den_t     den_d_r;
  tag_t     tag_d_r;

  always_ff @(posedge clk) begin
    if (rdy_d && vld_c_r) begin
      for (int i = 0; i < 3; i++) begin
        num_d_r[i] <= NUM_WIDTH'(prod_c_r[i]) + NUM_WIDTH'(mx_c_r);
      end
      den_d_r <= {mx_c_r, 1'b0};
      tag_d_r <= tag_c_r;
    end
  end

  // --------------------------------------------------------------------------
  // Divider
  // --------------------------------------------------------------------------
  quot_vec_t div_quot;
  tag_t      div_tag;

  cfdt_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_d_r),
    .in_ready  (div_in_ready),
    .in_num    (num_d_r),
    .in_den    (den_d_r),
    .in_tag    (tag_d_r),
    .out_valid (div_out_valid),
    .out_ready (rdy_e),
    .out_quot  (div_quot),
    .out_tag   (div_tag)
  );

  // --------------------------------------------------------------------------
  // Output stage: signed hit point and texel
  // --------------------------------------------------------------------------
  logic signed [QUOT_WIDTH:0]   hs [3];
  logic signed [CALC_WIDTH-1:0] hc [3];
  logic signed [CALC_WIDTH-1:0] h1, h3, h5, h7;
  logic signed [CALC_WIDTH-1:0] u_nxt, v_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hs[i] = signed'({1'b0, div_quot[i]});
      if (div_tag.neg[i]) hs[i] = -hs[i];
      hc[i] = CALC_WIDTH'(hs[i]);
    end
    h1 = signed'(CALC_WIDTH'(half1_r));
    h3 = signed'(CALC_WIDTH'(half3_r));
    h5 = signed'(CALC_WIDTH'(half5_r));
    h7 = signed'(CALC_WIDTH'(half7_r));
    unique case (div_tag.face)
      FACE_FRONT: begin
        u_nxt = h3 - hc[1];
        v_nxt = h3 - hc[2];
      end
      FACE_BACK: begin
        u_nxt = h7 + hc[1];
        v_nxt = h3 - hc[2];
      end
      FACE_LEFT: begin
        u_nxt = h1 + hc[0];
        v_nxt = h3 - hc[2];
      end
      FACE_RIGHT: begin
        u_nxt = h5 - hc[0];
        v_nxt = h3 - hc[2];
      end
      FACE_TOP: begin
        u_nxt = h3 - hc[1];
        v_nxt = h1 + hc[0];
      end
      default: begin
        u_nxt = h3 - hc[1];
        v_nxt = h5 - hc[0];
      end
    endcase
  end

  logic [FACE_WIDTH-1:0] face_r;
  logic [HIT_WIDTH-1:0]  hit_r [3];
  logic [U_WIDTH-1:0]    u_r;
  logic [V_WIDTH-1:0]    v_r;
  logic                  zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy_e) begin
      out_vld_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && div_out_valid) begin
      zero_r <= div_tag.zero;
      if (div_tag.zero) begin
        face_r <= FACE_FRONT;
        for (int i = 0; i < 3; i++) hit_r[i] <= '0;
        u_r <= '0;
        v_r <= '0;
      end else begin
        face_r <= div_tag.face;
        for (int i = 0; i < 3; i++) hit_r[i] <= HIT_WIDTH'(hs[i]);
        u_r <= U_WIDTH'(u_nxt);
        v_r <= V_WIDTH'(v_nxt);
      end
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {7'b0, v_r, u_r, hit_r[2], hit_r[1], hit_r[0], face_r};
  assign out_tuser[0] = zero_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_zero_clears : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("zero vector result carries nonzero data");

  a_face_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= FACE_BOTTOM)
    else $error("face code out of range");

  a_drain_ready : assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

FILE: sv/cfdt_div_pipe.sv
// ----------------------------------------------------------------------------
// cfdt_div_pipe
// Pipelined restoring divider: three dividends over one shared divisor,
// one quotient bit per stage, with valid/ready flow control per stage.
// ----------------------------------------------------------------------------
module cfdt_div_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cfdt_pkg::num_vec_t  in_num,
  input  cfdt_pkg::den_t      in_den,
  input  cfdt_pkg::tag_t      in_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output cfdt_pkg::quot_vec_t out_quot,
  output cfdt_pkg::tag_t      out_tag
);
  import cfdt_pkg::*;

  localparam int STAGES = QUOT_WIDTH;

  logic [STAGES-1:0] vld_r;
  logic [STAGES:0]   rdy;
  num_vec_t          rem_r [STAGES];
  quot_vec_t         quo_r [STAGES];
  den_t              den_r [STAGES];
  tag_t              tag_r [STAGES];

  logic [STAGES-1:0] vld_in;
  num_vec_t          rem_in  [STAGES];
  quot_vec_t         quo_in  [STAGES];
  den_t              den_in  [STAGES];
  tag_t              tag_in  [STAGES];
  num_vec_t          rem_nxt [STAGES];
  quot_vec_t         quo_nxt [STAGES];

  assign rdy[STAGES] = out_ready;
  assign in_ready    = rdy[0];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int BIT = STAGES - 1 - s;

    if (s == 0) begin : g_first
      assign vld_in[s] = in_valid;
      assign rem_in[s] = in_num;
      assign quo_in[s] = '0;
      assign den_in[s] = in_den;
      assign tag_in[s] = in_tag;
    end else begin : g_next
      assign vld_in[s] = vld_r[s-1];
      assign rem_in[s] = rem_r[s-1];
      assign quo_in[s] = quo_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign tag_in[s] = tag_r[s-1];
    end

    assign rdy[s] = !vld_r[s] || rdy[s+1];

    // trial subtract of divisor << BIT
    always_comb begin
      num_t trial;
      trial = NUM_WIDTH'(den_in[s]) << BIT;
      rem_nxt[s] = rem_in[s];
      quo_nxt[s] = quo_in[s];
      for (int i = 0; i < 3; i++) begin
        if (rem_in[s][i] >= trial) begin
          rem_nxt[s][i]      = rem_in[s][i] - trial;
          quo_nxt[s][i][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_r[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vld_in[s]) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= den_in[s];
        tag_r[s] <= tag_in[s];
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_quot  = quo_r[STAGES-1];
  assign out_tag   = tag_r[STAGES-1];

endmodule
